FILE: rtl/core/tcgd_pkg.sv
// Shared constants, request codes and control structs of the text column gap detector.
package tcgd_pkg;

	// Column capacity and report limit
	localparam int MAX_WIDTH = 256;
	localparam int MAX_GAPS  = 64;

	// Column index and line length widths (length can reach MAX_WIDTH itself)
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int LEN_W = $clog2(MAX_WIDTH + 1);

	// Gap buffer addressing
	localparam int GAP_IDX_W = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;

	// Fixed payload widths
	localparam int REQ_W       = 2;
	localparam int CH_W        = 8;
	localparam int GAP_COL_W   = 8;
	localparam int GAP_TOTAL_W = 7;

	localparam logic [CH_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [1:0]      ROWS_NEEDED  = 2'd2;
	localparam logic [LEN_W-1:0] MIN_SCAN_LEN = LEN_W'(3);
	localparam logic [GAP_TOTAL_W-1:0] TABULAR_GAPS = GAP_TOTAL_W'(2);

	typedef enum logic [REQ_W-1:0] {
		REQ_CHAR = 2'd0,
		REQ_EOL  = 2'd1,
		REQ_EOB  = 2'd2
	} req_type_t;

	// Commands from the sequencer to the column map
	typedef struct packed {
		logic            add_char;
		logic [CH_W-1:0] ch;
		logic            end_line;
		logic            shift;
		logic            clear;
	} map_cmd_t;

	// Status from the column map: scan window and block statistics
	typedef struct packed {
		logic [2:0]       win;
		logic [LEN_W-1:0] shortest;
		logic [1:0]       rows;
	} map_stat_t;

	// Zero-extend or truncate a column index to the reported width
	function automatic logic [GAP_COL_W-1:0] to_gap_col(input logic [LEN_W-1:0] v);
		logic [LEN_W+GAP_COL_W-1:0] t;
		t = {{GAP_COL_W{1'b0}}, v};
		return t[GAP_COL_W-1:0];
	endfunction

endpackage

FILE: rtl/core/tcgd_req_if.sv
// Request channel: characters and line/block markers.
interface tcgd_req_if;
	logic                      valid;
	logic                      ready;
	logic [tcgd_pkg::REQ_W-1:0] req_type;
	logic [tcgd_pkg::CH_W-1:0]  ch;

	modport source (output valid, output req_type, output ch, input ready);
	modport sink   (input valid, input req_type, input ch, output ready);
endinterface

FILE: rtl/core/tcgd_rsp_if.sv
// Result channel: one transaction per gap, or one empty report per block.
interface tcgd_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tcgd_pkg::GAP_COL_W-1:0]   gap_column;
	logic                             gap_valid;
	logic [tcgd_pkg::GAP_TOTAL_W-1:0] gap_total;
	logic                             tabular;
	logic                             last;

	modport source (output valid, output gap_column, output gap_valid, output gap_total,
		output tabular, output last, input ready);
	modport sink   (input valid, input gap_column, input gap_valid, input gap_total,
		input tabular, input last, output ready);
endinterface

FILE: rtl/core/tcgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

FILE: rtl/core/tcgd_colmap.sv
// Column map: per-column text bitmap, line length tracking and the shifting scan window.
module tcgd_colmap (
	input  logic                clk,
	input  logic                arst_n,
	input  tcgd_pkg::map_cmd_t  cmd,
	output tcgd_pkg::map_stat_t stat
);
	// Bit c set: some row holds a non-space at column c (its complement is blank-in-all-rows)
	logic [tcgd_pkg::MAX_WIDTH-1:0] text_q;
	logic [tcgd_pkg::LEN_W-1:0]     cur_col_q;
	logic [tcgd_pkg::LEN_W-1:0]     shortest_q;
	logic [1:0]                     rows_q;
	logic                           col_in_range;

	assign col_in_range = cur_col_q < tcgd_pkg::LEN_W'(tcgd_pkg::MAX_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q     <= '0;
			cur_col_q  <= '0;
			shortest_q <= tcgd_pkg::LEN_W'(tcgd_pkg::MAX_WIDTH);
			rows_q     <= '0;
		end else if (cmd.clear) begin
			text_q     <= '0;
			cur_col_q  <= '0;
			shortest_q <= tcgd_pkg::LEN_W'(tcgd_pkg::MAX_WIDTH);
			rows_q     <= '0;
		end else if (cmd.shift) begin
			// Slide the next column into the three-bit window
			text_q <= {1'b0, text_q[tcgd_pkg::MAX_WIDTH-1:1]};
		end else if (cmd.add_char) begin
			if (col_in_range) begin
				if (cmd.ch != tcgd_pkg::SPACE_CHAR) begin
					text_q[cur_col_q[tcgd_pkg::COL_W-1:0]] <= 1'b1;
				end
				cur_col_q <= cur_col_q + 1'b1;
			end
		end else if (cmd.end_line) begin
			if (cur_col_q < shortest_q) begin
				shortest_q <= cur_col_q;
			end
			cur_col_q <= '0;
			if (rows_q < tcgd_pkg::ROWS_NEEDED) begin
				rows_q <= rows_q + 1'b1;
			end
		end
	end

	assign stat.win      = text_q[2:0];
	assign stat.shortest = shortest_q;
	assign stat.rows     = rows_q;
endmodule

FILE: rtl/core/text_column_gap_detector.sv
// Top level of the text column gap detector: sequencer, column map and gap buffer.
//
// Text arrives one transaction per character, line end or block end. Characters and
// line ends are taken one per cycle. A block end closes the last line and starts the
// block report: a check step, then a scan over columns 1 to shortest length minus 2
// at one column per cycle through the shifting window of the column map, then a step
// to close the scan (it stops early once MAX_GAPS gaps are found), then the report,
// which for each gap reads the single read port of the gap buffer and then loads the
// output register, holding while the result side stalls. A block with no gaps reports
// one empty transaction with last set. The request side is not ready from the block
// end until the last report transaction sits in the output register; the next block's
// characters are taken while that transaction still waits to be taken. Every gap
// transaction carries the block's gap count and the tabular flag (two or more gaps).
// Request code 3 is consumed and ignored.
module text_column_gap_detector (
	input  logic         clk,
	input  logic         arst_n,
	tcgd_req_if.sink     req,
	tcgd_rsp_if.source   rsp
);
	typedef enum logic [4:0] {
		S_ACCUM = 5'b00001,
		S_CHECK = 5'b00010,
		S_SCAN  = 5'b00100,
		S_READ  = 5'b01000,
		S_LOAD  = 5'b10000
	} state_t;

	state_t                           state_q;
	tcgd_pkg::map_cmd_t               map_cmd;
	tcgd_pkg::map_stat_t              map_stat;

	logic [tcgd_pkg::LEN_W-1:0]       col_q;      // column under test during the scan
	logic [tcgd_pkg::GAP_TOTAL_W-1:0] count_q;    // gaps found in this block
	logic [tcgd_pkg::GAP_TOTAL_W-1:0] emit_idx_q; // next gap to report

	logic                             req_fire;
	logic                             out_free;
	logic                             scan_more;
	logic                             gap_hit;
	logic                             emit_last;
	logic                             ram_wr;
	logic                             ram_rd;
	logic [tcgd_pkg::LEN_W-1:0]       ram_rdata;

	// Output register
	logic                             rsp_valid_q;
	logic [tcgd_pkg::GAP_COL_W-1:0]   rsp_col_q;
	logic                             rsp_gap_valid_q;
	logic [tcgd_pkg::GAP_TOTAL_W-1:0] rsp_total_q;
	logic                             rsp_tab_q;
	logic                             rsp_last_q;

	assign req.ready = (state_q == S_ACCUM);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Keep scanning while col + 1 < shortest length and the report has room
	assign scan_more = (({1'b0, col_q} + 1'b1) < {1'b0, map_stat.shortest}) &&
		(count_q < tcgd_pkg::GAP_TOTAL_W'(tcgd_pkg::MAX_GAPS));
	// Gap: blank in all rows here, text in some row on both sides
	assign gap_hit   = !map_stat.win[1] && map_stat.win[0] && map_stat.win[2];
	assign emit_last = (count_q == '0) || ((emit_idx_q + 1'b1) == count_q);

	assign ram_wr = (state_q == S_SCAN) && scan_more && gap_hit;
	assign ram_rd = (state_q == S_READ);

	// Column map commands
	always_comb begin
		map_cmd          = '0;
		map_cmd.ch       = req.ch;
		map_cmd.add_char = req_fire && (req.req_type == tcgd_pkg::REQ_CHAR);
		map_cmd.end_line = req_fire && ((req.req_type == tcgd_pkg::REQ_EOL) ||
			(req.req_type == tcgd_pkg::REQ_EOB));
		map_cmd.shift    = (state_q == S_SCAN) && scan_more;
		// Put the block state back once the scan is done or skipped
		map_cmd.clear    = ((state_q == S_SCAN) && !scan_more) ||
			((state_q == S_CHECK) && !((map_stat.rows >= tcgd_pkg::ROWS_NEEDED) &&
			(map_stat.shortest >= tcgd_pkg::MIN_SCAN_LEN)));
	end

	tcgd_colmap u_colmap (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.stat   (map_stat)
	);

	// Gap buffer: columns written during the scan, read back during the report
	tcgd_ram #(
		.WIDTH (tcgd_pkg::LEN_W),
		.DEPTH (tcgd_pkg::MAX_GAPS)
	) u_gap_buf (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (count_q[tcgd_pkg::GAP_IDX_W-1:0]),
		.wr_data (col_q),
		.rd_en   (ram_rd),
		.rd_addr (emit_idx_q[tcgd_pkg::GAP_IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_ACCUM;
			col_q      <= '0;
			count_q    <= '0;
			emit_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_ACCUM: begin
					if (req_fire && (req.req_type == tcgd_pkg::REQ_EOB)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					col_q      <= tcgd_pkg::LEN_W'(1);
					count_q    <= '0;
					emit_idx_q <= '0;
					if ((map_stat.rows >= tcgd_pkg::ROWS_NEEDED) &&
						(map_stat.shortest >= tcgd_pkg::MIN_SCAN_LEN)) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						col_q <= col_q + 1'b1;
						if (gap_hit) begin
							count_q <= count_q + 1'b1;
						end
					end else if (count_q == '0) begin
						state_q <= S_LOAD;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					// Hold until the output register frees up
					if (out_free) begin
						if (emit_last) begin
							state_q <= S_ACCUM;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
							state_q    <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_ACCUM;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_LOAD) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if ((state_q == S_LOAD) && out_free) begin
			rsp_gap_valid_q <= (count_q != '0);
			rsp_col_q       <= (count_q == '0) ? '0 : tcgd_pkg::to_gap_col(ram_rdata);
			rsp_total_q     <= count_q;
			rsp_tab_q       <= (count_q >= tcgd_pkg::TABULAR_GAPS);
			rsp_last_q      <= emit_last;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.gap_column = rsp_col_q;
	assign rsp.gap_valid  = rsp_gap_valid_q;
	assign rsp.gap_total  = rsp_total_q;
	assign rsp.tabular    = rsp_tab_q;
	assign rsp.last       = rsp_last_q;
endmodule

FILE: rtl/core/tcgd_checker.sv
// Port-level checks of the text column gap detector, bound to the top level.
module tcgd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic [tcgd_pkg::REQ_W-1:0]       req_type,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [tcgd_pkg::GAP_COL_W-1:0]   gap_column,
	input logic                             gap_valid,
	input logic [tcgd_pkg::GAP_TOTAL_W-1:0] gap_total,
	input logic                             tabular,
	input logic                             last
);
	// An empty report is a single final transaction with no gaps
	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !gap_valid |-> last && (gap_total == '0) && (gap_column == '0))
		else $error("empty report malformed");

	// A gap transaction carries a nonzero total and a consistent tabular flag
	a_tabular: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && gap_valid |-> (gap_total != '0) &&
		(tabular == (gap_total >= tcgd_pkg::TABULAR_GAPS)))
		else $error("gap total or tabular flag inconsistent");

	// A block end always stops the request side for the report
	a_eob_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == tcgd_pkg::REQ_EOB) |=> !req_ready)
		else $error("request taken right after block end");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(gap_column) &&
		$stable(gap_valid) && $stable(gap_total) && $stable(last))
		else $error("stalled result changed");
endmodule

bind text_column_gap_detector tcgd_checker u_tcgd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_type   (req.req_type),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.gap_column (rsp.gap_column),
	.gap_valid  (rsp.gap_valid),
	.gap_total  (rsp.gap_total),
	.tabular    (rsp.tabular),
	.last       (rsp.last)
);

FILE: verif/tcgd_gap_checker.sv
// Checker for the text column gap detector: predicts the gap reports of each text block and compares them.
`timescale 1ns / 1ps

module tcgd_gap_checker import tcgd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tcgd_req_if  req,
	tcgd_rsp_if  rsp,
	output int   fail_count,
	output int   requests_seen,
	output int   reports_due,
	output int   blocks_reported,
	output int   gaps_reported
);

	typedef struct packed {
		logic [GAP_COL_W-1:0]   gap_column;
		logic                   gap_valid;
		logic [GAP_TOTAL_W-1:0] gap_total;
		logic                   tabular;
		logic                   last;
	} gap_report_t;

	// Column map of the block being received
	logic [MAX_WIDTH-1:0] blank_cols;
	logic [MAX_WIDTH-1:0] inked_cols;
	logic [LEN_W-1:0]     min_len;
	logic [LEN_W-1:0]     col_pos;
	logic [1:0]           row_cnt;

	gap_report_t gap_reports_q[$];

	task automatic clear_map();
		blank_cols = '1;
		inked_cols = '0;
		min_len    = LEN_W'(MAX_WIDTH);
		col_pos    = '0;
		row_cnt    = '0;
	endtask

	task automatic close_line();
		if (col_pos < min_len)
			min_len = col_pos;
		col_pos = '0;
		if (row_cnt < ROWS_NEEDED)
			row_cnt = row_cnt + 2'd1;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gap_report_t          want;
		logic [GAP_COL_W-1:0] found [MAX_GAPS];
		int                   n;
		int                   col;
		int                   k;

		if (!arst_n) begin
			clear_map();
			gap_reports_q.delete();
			reports_due = 0;
		end else begin
			// Results first: a result taken at this edge can never stem from a block end taken now
			if (rsp.valid && rsp.ready) begin
				if (gap_reports_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual col=%0d valid=%0d total=%0d tabular=%0d last=%0d",
						$time, rsp.gap_column, rsp.gap_valid, rsp.gap_total, rsp.tabular, rsp.last);
					fail_count++;
				end else begin
					want = gap_reports_q.pop_front();
					check_field("gap_column", want.gap_column, rsp.gap_column);
					check_field("gap_valid", want.gap_valid, rsp.gap_valid);
					check_field("gap_total", want.gap_total, rsp.gap_total);
					check_field("tabular", want.tabular, rsp.tabular);
					check_field("last", want.last, rsp.last);
				end
				if (rsp.gap_valid)
					gaps_reported++;
				if (rsp.last)
					blocks_reported++;
			end

			if (req.valid && req.ready) begin
				requests_seen++;
				case (req.req_type)
					REQ_CHAR: begin
						if (col_pos < MAX_WIDTH) begin
							if (req.ch != SPACE_CHAR) begin
								blank_cols[col_pos] = 1'b0;
								inked_cols[col_pos] = 1'b1;
							end
							col_pos = col_pos + 1'b1;
						end
					end
					REQ_EOL: begin
						close_line();
					end
					REQ_EOB: begin
						close_line();
						n = 0;
						if (row_cnt >= ROWS_NEEDED && min_len >= MIN_SCAN_LEN) begin
							for (col = 1; col + 1 < min_len && n < MAX_GAPS; col++) begin
								if (blank_cols[col] && inked_cols[col-1] && inked_cols[col+1]) begin
									found[n] = GAP_COL_W'(col);
									n++;
								end
							end
						end
						if (n == 0) begin
							gap_reports_q.push_back('{gap_column: '0, gap_valid: 1'b0, gap_total: '0,
								tabular: 1'b0, last: 1'b1});
						end else begin
							for (k = 0; k < n; k++)
								gap_reports_q.push_back('{gap_column: found[k], gap_valid: 1'b1,
									gap_total: GAP_TOTAL_W'(n), tabular: (n >= TABULAR_GAPS),
									last: (k == n - 1)});
						end
						clear_map();
					end
					default: ;
				endcase
			end
			reports_due = gap_reports_q.size();
		end
	end

endmodule

FILE: verif/text_column_gap_detector_tb.sv
// Testbench top of the text column gap detector: clock, reset, text stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module text_column_gap_detector_tb;
	import tcgd_pkg::*;

	// Request code the block must swallow without effect
	localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

	// Random items in the random part, not counting the wide block
	localparam int RANDOM_ITEMS = 270;

	// Cycles of result hold-off used to back up the block into its input
	localparam int LONG_HOLD = 400;

	// Cycles to watch for stray results after the last expected one (worst scan plus report)
	localparam int SETTLE_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;

	tcgd_req_if req_ch ();
	tcgd_rsp_if rsp_ch ();

	int fail_count;
	int requests_seen;
	int reports_due;
	int blocks_reported;
	int gaps_reported;

	int sent_count;
	bit sender_steady;
	bit hold_rsp_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_column_gap_detector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tcgd_gap_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.fail_count      (fail_count),
		.requests_seen   (requests_seen),
		.reports_due     (reports_due),
		.blocks_reported (blocks_reported),
		.gaps_reported   (gaps_reported)
	);

	// Idle length: mostly none or short, now and then a long one
	function automatic int pick_idle(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Any byte but the space
	function automatic logic [CH_W-1:0] text_byte();
		logic [CH_W-1:0] b;
		b = CH_W'($urandom_range(0, 255));
		if (b == SPACE_CHAR)
			b = 8'h21;
		return b;
	endfunction

	// Offer one transaction after a random idle stretch and hold it until taken.
	// Keep valid high across back-to-back transactions so it gets one assignment per step.
	task automatic send_item(input logic [REQ_W-1:0] kind, input logic [CH_W-1:0] c);
		int n;
		n = pick_idle(sender_steady);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.ch       <= c;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_item(REQ_CHAR, s[i]);
	endtask

	// Block until every sent transaction is seen and every predicted result has come back
	task automatic wait_all_reported();
		wait (requests_seen == sent_count && reports_due == 0);
	endtask

	// A well-formed block: column template with planted gap columns, random text around them.
	// Some blocks come out broken: a single row, ragged or short rows, very narrow widths.
	task automatic send_random_block();
		int width;
		int rows;
		int len;
		int r;
		int c;
		logic [31:0] gap_mask;

		sender_steady = ($urandom_range(0, 3) == 0);
		width = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(3, 24);
		rows  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 4);
		gap_mask = '0;
		for (c = 1; c + 1 < width; c++)
			gap_mask[c] = ($urandom_range(0, 2) == 0);
		for (r = 0; r < rows; r++) begin
			len = width;
			case ($urandom_range(0, 9))
				0, 1: len = width + $urandom_range(1, 6);
				2: len = $urandom_range(0, width);
				default: ;
			endcase
			for (c = 0; c < len; c++)
				send_item(REQ_CHAR, ((c < width && gap_mask[c]) || $urandom_range(0, 2) == 0) ?
					SPACE_CHAR : text_byte());
			send_item((r == rows - 1) ? REQ_EOB : REQ_EOL, CH_W'($urandom_range(0, 255)));
		end
	endtask

	// Alternating text and space so every odd column is a gap: more gap candidates than
	// the report can carry. The first row runs past the column capacity with text only,
	// so a wrapped column index would wipe out the first gaps.
	task automatic send_wide_block();
		int c;
		for (c = 0; c < MAX_WIDTH + 4; c++)
			send_item(REQ_CHAR, (c >= MAX_WIDTH || c % 2 == 0) ? text_byte() : SPACE_CHAR);
		send_item(REQ_EOL, CH_W'($urandom_range(0, 255)));
		for (c = 0; c < 2 * MAX_GAPS + 5; c++)
			send_item(REQ_CHAR, (c % 2 == 0) ? text_byte() : SPACE_CHAR);
		// Stall the result side while the report is built, so the input backs up behind it
		hold_rsp_req = 1'b1;
		send_item(REQ_EOB, CH_W'($urandom_range(0, 255)));
	endtask

	// Result side: random ready stretches and stalls, a long hold-off on request
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
				rsp_ch.ready <= 1'b1;
				repeat (n) @(posedge clk);
				n = pick_idle(1'b0);
				if (n > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int directed_items;
		int wide_items;
		int mark;
		bit wide_done;
		bit paused;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_CHAR;
		req_ch.ch       = '0;
		sent_count      = 0;
		sender_steady   = 1'b0;
		hold_rsp_req    = 1'b0;
		wide_items      = 0;
		wide_done       = 1'b0;
		paused          = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unknown request code on an idle block: no state change, no result
		send_item(REQ_IGNORED, 8'hFF);
		// Two rows of three columns: one gap in the middle, not tabular
		send_text("a b");
		send_item(REQ_EOL, 8'h00);
		send_text("c d");
		send_item(REQ_EOB, 8'hFF);
		// Two gaps, tabular; second row uses the byte extremes as text
		send_text("a b c");
		send_item(REQ_EOL, 8'hFF);
		send_item(REQ_CHAR, 8'hFF);
		send_item(REQ_CHAR, SPACE_CHAR);
		send_item(REQ_CHAR, 8'h00);
		send_item(REQ_CHAR, SPACE_CHAR);
		send_item(REQ_CHAR, 8'h80);
		send_item(REQ_EOB, 8'h00);
		// Lone block end: a single empty row, so an empty report
		send_item(REQ_EOB, 8'hAA);
		directed_items = sent_count;

		while (sent_count - directed_items - wide_items < RANDOM_ITEMS) begin
			// Noise between blocks: ignored codes, stray characters, empty lines
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 2))
						0: send_item(REQ_IGNORED, CH_W'($urandom_range(0, 255)));
						1: send_item(REQ_CHAR, CH_W'($urandom_range(0, 255)));
						default: send_item(REQ_EOL, CH_W'($urandom_range(0, 255)));
					endcase
				end
			end
			send_random_block();

			if (!wide_done && sent_count - directed_items >= RANDOM_ITEMS / 2) begin
				mark = sent_count;
				sender_steady = ($urandom_range(0, 1) == 0);
				send_wide_block();
				wide_items = sent_count - mark;
				wide_done  = 1'b1;
			end else if (wide_done && !paused) begin
				// Drop valid and hold the sender until the capped report has fully drained
				req_ch.valid <= 1'b0;
				wait_all_reported();
				paused = 1'b1;
			end
		end
		req_ch.valid <= 1'b0;

		wait_all_reported();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d transactions in directed and random blocks, including one wide block.",
			sent_count);
		$display("Checked %0d block reports carrying %0d gaps.", blocks_reported, gaps_reported);
		if (fail_count == 0) begin
			$display("PASS text_column_gap_detector");
		end else begin
			$display("FAIL text_column_gap_detector");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("FAIL text_column_gap_detector");
		$finish;
	end

endmodule

FILE: text_column_gap_detector.f
rtl/core/tcgd_pkg.sv
rtl/core/tcgd_req_if.sv
rtl/core/tcgd_rsp_if.sv
rtl/core/tcgd_ram.sv
rtl/core/tcgd_colmap.sv
rtl/core/text_column_gap_detector.sv
rtl/core/tcgd_checker.sv
verif/tcgd_gap_checker.sv
verif/text_column_gap_detector_tb.sv
